@@ hw/rtl/ifc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ifc_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [6:0] POS_LIMIT = 7'd127;

    localparam logic [1:0] CFG_LOCAL_ADDR     = 2'd0;
    localparam logic [1:0] CFG_NET_PATTERN    = 2'd1;
    localparam logic [1:0] CFG_TRACE_PORT_MIN = 2'd2;

    localparam logic [31:0] LOCAL_ADDR_RST     = 32'h0000_0000;
    localparam logic [31:0] NET_PATTERN_RST    = 32'h0a0a_0a00;
    localparam logic [15:0] TRACE_PORT_MIN_RST = 16'd33434;

    localparam logic [2:0] EV_PING   = 3'd0;
    localparam logic [2:0] EV_PONG   = 3'd1;
    localparam logic [2:0] EV_TRACE  = 3'd2;
    localparam logic [2:0] EV_SYN    = 3'd3;
    localparam logic [2:0] EV_FIN    = 3'd4;
    localparam logic [2:0] EV_IGMP   = 3'd5;
    localparam logic [2:0] EV_OTHER  = 3'd6;
    localparam logic [2:0] EV_TRUNC  = 3'd7;

    localparam logic [3:0] SVC_FTP       = 4'd0;
    localparam logic [3:0] SVC_SSH       = 4'd1;
    localparam logic [3:0] SVC_TELNET    = 4'd2;
    localparam logic [3:0] SVC_SMTP      = 4'd3;
    localparam logic [3:0] SVC_GOPHER    = 4'd4;
    localparam logic [3:0] SVC_FINGER    = 4'd5;
    localparam logic [3:0] SVC_WWW       = 4'd6;
    localparam logic [3:0] SVC_POP2      = 4'd7;
    localparam logic [3:0] SVC_POP3      = 4'd8;
    localparam logic [3:0] SVC_AUTH      = 4'd9;
    localparam logic [3:0] SVC_FTP_REPLY = 4'd10;
    localparam logic [3:0] SVC_UNKNOWN   = 4'd11;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4  = 4'd4;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_IGMP    = 8'd2;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    typedef struct packed {
        logic [31:0] local_addr;
        logic [31:0] net_pattern;
        logic [15:0] trace_port_min;
    } cfg_t;

    // Fields captured from one frame, handed from the front to the back.
    typedef struct packed {
        logic [6:0]  seen;
        logic [15:0] ether_type;
        logic [3:0]  version;
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [5:0]  flags;
        logic [3:0]  tcount;
    } frame_rec_t;

    typedef struct packed {
        logic [2:0]  event_class;
        logic [3:0]  service_code;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } event_t;

endpackage

`default_nettype wire

@@ hw/rtl/inbound_frame_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake                    Payload
// bytes      in         push / full                  frame_byte, last_byte
// events     out        empty / pop                  event_class .. dst_port
// config     in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One frame byte is taken every cycle while full is low; bytes only update
// the capture registers of the front stage.
// On the last byte the captured fields enter a short queue; the back stage
// classifies one frame a cycle while its output slot is free or being drained,
// and registers its event in the output slot that drives the result ports.
// Filtered frames leave the queue without producing an event.
// full rises only while the queue is full and then holds every byte, so a
// stalled output backs up into the byte side once the queue has filled.
// Reset clears all control state.
module inbound_frame_classifier #(
    parameter int unsigned QUEUE_DEPTH = ifc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output      logic        full,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        last_byte,
    output      logic        empty,
    input  wire logic        pop,
    output      logic [2:0]  event_class,
    output      logic [3:0]  service_code,
    output      logic [31:0] src_addr,
    output      logic [31:0] dst_addr,
    output      logic [15:0] src_port,
    output      logic [15:0] dst_port,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import ifc_pkg::*;

    logic        accept;
    logic        rec_push;
    frame_rec_t  rec_in;
    frame_rec_t  rec_out;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    event_t      evt;
    logic        evt_valid;
    logic        out_pop;
    cfg_t        cfg_reg;
    cfg_t        cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LOCAL_ADDR:     cfg_next.local_addr     = cfg_data;
                CFG_NET_PATTERN:    cfg_next.net_pattern    = cfg_data;
                CFG_TRACE_PORT_MIN: cfg_next.trace_port_min = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_addr     <= LOCAL_ADDR_RST;
            cfg_reg.net_pattern    <= NET_PATTERN_RST;
            cfg_reg.trace_port_min <= TRACE_PORT_MIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    ifc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .rec_push   (rec_push),
        .rec_data   (rec_in)
    );

    ifc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec_in),
        .rd_en   (q_pop),
        .rd_data (rec_out),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    ifc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rec       (rec_out),
        .rec_empty (q_empty),
        .rec_pop   (q_pop),
        .evt       (evt),
        .evt_valid (evt_valid),
        .evt_pop   (out_pop)
    );

    assign empty        = !evt_valid;
    assign out_pop      = pop && evt_valid;
    assign event_class  = evt.event_class;
    assign service_code = evt.service_code;
    assign src_addr     = evt.src_addr;
    assign dst_addr     = evt.dst_addr;
    assign src_port     = evt.src_port;
    assign dst_port     = evt.dst_port;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("record taken from an empty queue");

    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (empty || pop))
        else $error("back stage overwrote a waiting event");

    a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_class == EV_TRUNC) |->
            (src_port == 16'd0 && dst_port == 16'd0 && service_code == 4'd0))
        else $error("truncated event carries port fields");

    a_svc_syn_only: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_class != EV_SYN) |-> (service_code == 4'd0))
        else $error("service code outside a syn event");

endmodule

`default_nettype wire

@@ hw/rtl/ifc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ifc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        frame_byte,
    input  wire logic              last_byte,
    output      logic              rec_push,
    output      ifc_pkg::frame_rec_t rec_data
);
    import ifc_pkg::*;

    logic [6:0]  pos_reg;
    logic [6:0]  pos_next;
    logic [3:0]  ihl_reg;
    logic [3:0]  ihl_next;
    frame_rec_t  rec_reg;
    frame_rec_t  rec_next;
    frame_rec_t  cur;
    logic [3:0]  ihl_eff;
    logic [6:0]  start;
    logic [6:0]  rel;
    logic        in_win;
    logic        live;

    always_comb
    begin
        live    = (pos_reg != POS_LIMIT);
        ihl_eff = (pos_reg == 7'd14) ? frame_byte[3:0] : ihl_reg;
        start   = 7'd14 + {1'b0, ihl_eff, 2'b00};
        rel     = pos_reg - start;
        in_win  = live && (pos_reg >= start) && (rel < 7'd15);

        cur      = rec_reg;
        cur.seen = live ? (pos_reg + 7'd1) : POS_LIMIT;
        if (live)
        begin
            case (pos_reg)
                7'd12: cur.ether_type[15:8] = frame_byte;
                7'd13: cur.ether_type[7:0]  = frame_byte;
                7'd14: cur.version          = frame_byte[7:4];
                7'd23: cur.protocol         = frame_byte;
                7'd26: cur.src_ip[31:24]    = frame_byte;
                7'd27: cur.src_ip[23:16]    = frame_byte;
                7'd28: cur.src_ip[15:8]     = frame_byte;
                7'd29: cur.src_ip[7:0]      = frame_byte;
                7'd30: cur.dst_ip[31:24]    = frame_byte;
                7'd31: cur.dst_ip[23:16]    = frame_byte;
                7'd32: cur.dst_ip[15:8]     = frame_byte;
                7'd33: cur.dst_ip[7:0]      = frame_byte;
                default: ;
            endcase
        end
        // Transport window may overlap the IP header when IHL is small.
        if (in_win)
        begin
            case (rel[3:0])
                4'd0:  cur.sport[15:8] = frame_byte;
                4'd1:  cur.sport[7:0]  = frame_byte;
                4'd2:  cur.dport[15:8] = frame_byte;
                4'd3:  cur.dport[7:0]  = frame_byte;
                4'd13: cur.flags       = frame_byte[5:0];
                default: ;
            endcase
            cur.tcount = rel[3:0] + 4'd1;
        end

        pos_next = pos_reg;
        ihl_next = ihl_reg;
        rec_next = rec_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                pos_next = '0;
                ihl_next = '0;
                rec_next = '0;
            end
            else
            begin
                pos_next = cur.seen;
                ihl_next = ihl_eff;
                rec_next = cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ihl_reg <= '0;
            rec_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            ihl_reg <= ihl_next;
            rec_reg <= rec_next;
        end
    end

    assign rec_push = accept && last_byte;
    assign rec_data = cur;

endmodule

`default_nettype wire

@@ hw/rtl/ifc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ifc_queue #(
    parameter int unsigned DEPTH = ifc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire ifc_pkg::frame_rec_t wr_data,
    input  wire logic                rd_en,
    output      ifc_pkg::frame_rec_t rd_data,
    output      logic                q_full,
    output      logic                q_empty
);
    import ifc_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    frame_rec_t      slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;

    assign q_full  = (cnt_reg == FULL_CNT);
    assign q_empty = (cnt_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ifc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ifc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ifc_pkg::cfg_t       cfg,
    input  wire ifc_pkg::frame_rec_t rec,
    input  wire logic                rec_empty,
    output      logic                rec_pop,
    output      ifc_pkg::event_t     evt,
    output      logic                evt_valid,
    input  wire logic                evt_pop
);
    import ifc_pkg::*;

    logic        hit;
    event_t      cand;
    logic [3:0]  need;
    logic        valid_reg;
    logic        valid_next;
    event_t      evt_reg;

    function automatic logic [3:0] service_of(input logic [15:0] dport,
                                              input logic [15:0] sport);
        logic [3:0] code;
        begin
            case (dport)
                16'd21:  code = SVC_FTP;
                16'd22:  code = SVC_SSH;
                16'd23:  code = SVC_TELNET;
                16'd25:  code = SVC_SMTP;
                16'd70:  code = SVC_GOPHER;
                16'd79:  code = SVC_FINGER;
                16'd80:  code = SVC_WWW;
                16'd109: code = SVC_POP2;
                16'd110: code = SVC_POP3;
                16'd113: code = SVC_AUTH;
                default: code = (sport != 16'd0) ? SVC_FTP_REPLY : SVC_UNKNOWN;
            endcase
            return code;
        end
    endfunction

    always_comb
    begin
        hit               = 1'b1;
        cand.event_class  = EV_OTHER;
        cand.service_code = '0;
        cand.src_addr     = rec.src_ip;
        cand.dst_addr     = rec.dst_ip;
        cand.src_port     = '0;
        cand.dst_port     = '0;

        case (rec.protocol)
            PROTO_ICMP: need = 4'd1;
            PROTO_UDP:  need = 4'd4;
            PROTO_TCP:  need = 4'd14;
            default:    need = 4'd0;
        endcase

        if (rec.seen < 7'd14)
        begin
            cand.event_class = EV_TRUNC;
        end
        else if (rec.ether_type != ETH_TYPE_IPV4)
        begin
            hit = 1'b0;
        end
        else if (rec.seen < 7'd15)
        begin
            cand.event_class = EV_TRUNC;
        end
        else if (rec.version != IP_VERSION_4)
        begin
            hit = 1'b0;
        end
        else if (rec.seen < 7'd34)
        begin
            cand.event_class = EV_TRUNC;
        end
        else if (rec.dst_ip != cfg.local_addr)
        begin
            hit = 1'b0;
        end
        else if ((rec.src_ip & cfg.net_pattern) == cfg.net_pattern)
        begin
            hit = 1'b0;
        end
        else if (rec.tcount < need)
        begin
            cand.event_class = EV_TRUNC;
        end
        else
        begin
            case (rec.protocol)
                PROTO_ICMP:
                begin
                    // ICMP type sits in the first transport byte
                    if (rec.sport[15:8] == 8'd8)
                    begin
                        cand.event_class = EV_PING;
                    end
                    else if (rec.sport[15:8] == 8'd0)
                    begin
                        cand.event_class = EV_PONG;
                    end
                    else
                    begin
                        hit = 1'b0;
                    end
                end
                PROTO_UDP:
                begin
                    if (rec.dport >= cfg.trace_port_min)
                    begin
                        cand.event_class = EV_TRACE;
                        cand.dst_port    = rec.dport;
                    end
                    else
                    begin
                        hit = 1'b0;
                    end
                end
                PROTO_TCP:
                begin
                    if (rec.flags == 6'h02)
                    begin
                        cand.event_class  = EV_SYN;
                        cand.service_code = service_of(rec.dport, rec.sport);
                        cand.src_port     = rec.sport;
                        cand.dst_port     = rec.dport;
                    end
                    else if (rec.flags == 6'h01)
                    begin
                        cand.event_class = EV_FIN;
                        cand.src_port    = rec.sport;
                        cand.dst_port    = rec.dport;
                    end
                    else
                    begin
                        hit = 1'b0;
                    end
                end
                PROTO_IGMP: cand.event_class = EV_IGMP;
                default:    cand.event_class = EV_OTHER;
            endcase
        end
    end

    // Take a record whenever the output slot is free or being drained.
    assign rec_pop = !rec_empty && (!valid_reg || evt_pop);

    always_comb
    begin
        valid_next = valid_reg;
        if (rec_pop)
        begin
            valid_next = hit;
        end
        else if (evt_pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop && hit)
        begin
            evt_reg <= cand;
        end
    end

    assign evt       = evt_reg;
    assign evt_valid = valid_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ifc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned RANDOM_PHASES = 5;
    localparam int unsigned PHASE_BYTES   = 50;

    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
    localparam logic [5:0] TCP_FLAG_FIN      = 6'h01;
    localparam logic [5:0] TCP_FLAG_SYN      = 6'h02;
    localparam logic [7:0] TCP_FLAG_ACK      = 8'h10;

    localparam logic [15:0] PORT_FTP    = 16'd21;
    localparam logic [15:0] PORT_SSH    = 16'd22;
    localparam logic [15:0] PORT_TELNET = 16'd23;
    localparam logic [15:0] PORT_SMTP   = 16'd25;
    localparam logic [15:0] PORT_GOPHER = 16'd70;
    localparam logic [15:0] PORT_FINGER = 16'd79;
    localparam logic [15:0] PORT_WWW    = 16'd80;
    localparam logic [15:0] PORT_POP2   = 16'd109;
    localparam logic [15:0] PORT_POP3   = 16'd110;
    localparam logic [15:0] PORT_AUTH   = 16'd113;

    localparam logic [31:0] HOST_ADDR = 32'hC0A8_0A02;
    localparam logic [31:0] PEER_ADDR = 32'hAC10_0001;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  frame_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        pop = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_LOCAL_ADDR;
    logic [31:0] cfg_data = 32'd0;
    wire         full;
    wire         empty;
    wire         cfg_ready;
    wire [2:0]   event_class;
    wire [3:0]   service_code;
    wire [31:0]  src_addr;
    wire [31:0]  dst_addr;
    wire [15:0]  src_port;
    wire [15:0]  dst_port;

    // register copies
    logic [31:0] cur_local = LOCAL_ADDR_RST;
    logic [31:0] cur_pattern = NET_PATTERN_RST;
    logic [15:0] cur_floor = TRACE_PORT_MIN_RST;

    // per-frame capture
    logic [6:0]  f_pos = '0;
    logic [15:0] f_etype = '0;
    logic [7:0]  f_vihl = '0;
    logic [7:0]  f_proto = '0;
    logic [31:0] f_src = '0;
    logic [31:0] f_dst = '0;
    logic [63:0] f_thead = '0;
    logic [3:0]  f_tcount = '0;

    event_t      pending_events[$];
    event_t      oldest_event;
    logic [7:0]  frame_buf[$];
    logic [15:0] service_ports[10] = '{PORT_FTP, PORT_SSH, PORT_TELNET, PORT_SMTP,
        PORT_GOPHER, PORT_FINGER, PORT_WWW, PORT_POP2, PORT_POP3, PORT_AUTH};

    bit          steady = 1'b0;
    int unsigned pop_hold = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned events_checked = 0;
    int unsigned events_expected = 0;
    int unsigned bytes_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned reg_writes = 0;

    inbound_frame_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte),
        .empty        (empty),
        .pop          (pop),
        .event_class  (event_class),
        .service_code (service_code),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .src_port     (src_port),
        .dst_port     (dst_port),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d events outstanding", $time,
                     pending_events.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned stall_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random pop stalls, none while steady
    always @(posedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold = pop_hold - 1;
        end
        else if (!steady && $urandom_range(0, 99) < 20)
        begin
            pop <= 1'b0;
            pop_hold = stall_len() - 1;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: event_class expected none, actual %0h", $time,
                         event_class);
                mismatches++;
            end
            else
            begin
                oldest_event = pending_events.pop_front();
                check_field("event_class", oldest_event.event_class, event_class);
                check_field("service_code", oldest_event.service_code, service_code);
                check_field("src_addr", oldest_event.src_addr, src_addr);
                check_field("dst_addr", oldest_event.dst_addr, dst_addr);
                check_field("src_port", oldest_event.src_port, src_port);
                check_field("dst_port", oldest_event.dst_port, dst_port);
                events_checked++;
            end
        end
    end

    function automatic logic [3:0] service_for(input logic [15:0] dport,
                                               input logic [15:0] sport);
        case (dport)
            PORT_FTP:    return SVC_FTP;
            PORT_SSH:    return SVC_SSH;
            PORT_TELNET: return SVC_TELNET;
            PORT_SMTP:   return SVC_SMTP;
            PORT_GOPHER: return SVC_GOPHER;
            PORT_FINGER: return SVC_FINGER;
            PORT_WWW:    return SVC_WWW;
            PORT_POP2:   return SVC_POP2;
            PORT_POP3:   return SVC_POP3;
            PORT_AUTH:   return SVC_AUTH;
            default:     return (sport != 16'd0) ? SVC_FTP_REPLY : SVC_UNKNOWN;
        endcase
    endfunction

    function automatic bit classify_frame(output event_t ev);
        int unsigned seen;
        int unsigned need;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [5:0]  flags;
        seen = f_pos;
        sport = f_thead[31:16];
        dport = f_thead[15:0];
        flags = f_thead[37:32];
        ev = '0;
        ev.src_addr = f_src;
        ev.dst_addr = f_dst;
        ev.event_class = EV_TRUNC;
        if (seen < 14)
            return 1'b1;
        if (f_etype != ETH_TYPE_IPV4)
            return 1'b0;
        if (seen < 15)
            return 1'b1;
        if (f_vihl[7:4] != IP_VERSION_4)
            return 1'b0;
        if (seen < 34)
            return 1'b1;
        if (f_dst != cur_local || (f_src & cur_pattern) == cur_pattern)
            return 1'b0;
        case (f_proto)
            PROTO_ICMP: need = 1;
            PROTO_UDP:  need = 4;
            PROTO_TCP:  need = 14;
            default:    need = 0;
        endcase
        if (f_tcount < need)
            return 1'b1;
        case (f_proto)
            PROTO_ICMP:
            begin
                if (f_thead[31:24] == ICMP_ECHO_REQUEST)
                    ev.event_class = EV_PING;
                else if (f_thead[31:24] == ICMP_ECHO_REPLY)
                    ev.event_class = EV_PONG;
                else
                    return 1'b0;
            end
            PROTO_UDP:
            begin
                if (dport < cur_floor)
                    return 1'b0;
                ev.event_class = EV_TRACE;
                ev.dst_port = dport;
            end
            PROTO_TCP:
            begin
                if (flags == TCP_FLAG_SYN)
                begin
                    ev.event_class = EV_SYN;
                    ev.service_code = service_for(dport, sport);
                end
                else if (flags == TCP_FLAG_FIN)
                    ev.event_class = EV_FIN;
                else
                    return 1'b0;
                ev.src_port = sport;
                ev.dst_port = dport;
            end
            PROTO_IGMP: ev.event_class = EV_IGMP;
            default:    ev.event_class = EV_OTHER;
        endcase
        return 1'b1;
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic lst);
        int unsigned pos;
        int unsigned start;
        int unsigned rel;
        event_t      ev;
        pos = f_pos;
        if (pos < POS_LIMIT)
        begin
            if (pos == 12) f_etype[15:8] = b;
            if (pos == 13) f_etype[7:0] = b;
            if (pos == 14) f_vihl = b;
            if (pos == 23) f_proto = b;
            if (pos >= 26 && pos <= 29) f_src[8 * (29 - pos) +: 8] = b;
            if (pos >= 30 && pos <= 33) f_dst[8 * (33 - pos) +: 8] = b;
            // transport start follows the IHL known after this byte
            start = 14 + 4 * f_vihl[3:0];
            if (pos >= start && pos - start < 15)
            begin
                rel = pos - start;
                if (rel < 4) f_thead[8 * (3 - rel) +: 8] = b;
                if (rel == 13) f_thead[39:32] = b;
                f_tcount = 4'(rel + 1);
            end
            f_pos = 7'(pos + 1);
        end
        if (lst)
        begin
            if (classify_frame(ev))
            begin
                pending_events.push_back(ev);
                events_expected++;
            end
            f_pos = '0;
            f_etype = '0;
            f_vihl = '0;
            f_proto = '0;
            f_src = '0;
            f_dst = '0;
            f_thead = '0;
            f_tcount = '0;
        end
    endtask

    // push stays high after a transfer; the next byte or quiesce replaces it
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int unsigned gap;
        gap = (steady || $urandom_range(0, 99) < 70) ? 0 : stall_len();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        frame_byte <= b;
        last_byte <= lst;
        @(posedge clk);
        while (full) @(posedge clk);
        absorb_byte(b, lst);
        bytes_sent++;
    endtask

    task automatic send_frame(input int unsigned len);
        while (frame_buf.size() < len) frame_buf.push_back(8'($urandom_range(0, 255)));
        while (frame_buf.size() > len) frame_buf.delete(frame_buf.size() - 1);
        for (int i = 0; i < len; i++)
            send_byte(frame_buf[i], i == len - 1);
        frames_sent++;
    endtask

    task automatic build_ipv4(input int unsigned ihl, input logic [7:0] proto,
                              input logic [31:0] src, input logic [31:0] dst);
        int unsigned hdr_end;
        hdr_end = 14 + 4 * ihl;
        if (hdr_end < 34) hdr_end = 34;
        frame_buf.delete();
        for (int i = 0; i < hdr_end; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf[12] = ETH_TYPE_IPV4[15:8];
        frame_buf[13] = ETH_TYPE_IPV4[7:0];
        frame_buf[14] = {IP_VERSION_4, 4'(ihl)};
        frame_buf[23] = proto;
        for (int i = 0; i < 4; i++)
        begin
            frame_buf[26 + i] = src[31 - 8 * i -: 8];
            frame_buf[30 + i] = dst[31 - 8 * i -: 8];
        end
    endtask

    task automatic poke(input int unsigned idx, input logic [7:0] b);
        while (frame_buf.size() <= idx) frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf[idx] = b;
    endtask

    task automatic set_ports(input int unsigned ihl, input logic [15:0] sport,
                             input logic [15:0] dport);
        poke(14 + 4 * ihl, sport[15:8]);
        poke(15 + 4 * ihl, sport[7:0]);
        poke(16 + 4 * ihl, dport[15:8]);
        poke(17 + 4 * ihl, dport[7:0]);
    endtask

    task automatic tcp_segment(input logic [15:0] sport, input logic [15:0] dport,
                               input logic [7:0] flags);
        build_ipv4(5, PROTO_TCP, PEER_ADDR, cur_local);
        set_ports(5, sport, dport);
        poke(14 + 20 + 13, flags);
        send_frame(48);
    endtask

    task automatic icmp_message(input logic [31:0] src, input logic [7:0] icmp_type);
        build_ipv4(5, PROTO_ICMP, src, cur_local);
        poke(34, icmp_type);
        send_frame(35);
    endtask

    task automatic udp_datagram(input logic [15:0] dport);
        build_ipv4(5, PROTO_UDP, PEER_ADDR, cur_local);
        set_ports(5, 16'($urandom), dport);
        send_frame(38);
    endtask

    // hold the byte side and let the block run dry
    task automatic quiesce();
        push <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_LOCAL_ADDR:     cur_local = data;
            CFG_NET_PATTERN:    cur_pattern = data;
            CFG_TRACE_PORT_MIN: cur_floor = data[15:0];
            default:            ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_setting(input logic [31:0] local_addr,
                                 input logic [31:0] net_pattern,
                                 input logic [15:0] port_floor);
        quiesce();
        write_reg(CFG_LOCAL_ADDR, local_addr);
        write_reg(CFG_NET_PATTERN, net_pattern);
        write_reg(CFG_TRACE_PORT_MIN, {16'd0, port_floor});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_register_defaults();
        icmp_message(PEER_ADDR, ICMP_ECHO_REQUEST);
        udp_datagram(TRACE_PORT_MIN_RST);
        udp_datagram(TRACE_PORT_MIN_RST - 16'd1);
        icmp_message({NET_PATTERN_RST[31:8], 8'h37}, ICMP_ECHO_REQUEST);
    endtask

    task automatic test_truncation();
        frame_buf.delete();
        send_frame(1);
        build_ipv4(5, PROTO_TCP, PEER_ADDR, cur_local);
        send_frame(13);
        build_ipv4(5, PROTO_TCP, PEER_ADDR, cur_local);
        send_frame(14);
        build_ipv4(5, PROTO_ICMP, PEER_ADDR, cur_local);
        send_frame(30);
        build_ipv4(5, PROTO_ICMP, PEER_ADDR, cur_local);
        send_frame(34);
        build_ipv4(5, PROTO_UDP, PEER_ADDR, cur_local);
        send_frame(37);
        build_ipv4(5, PROTO_TCP, PEER_ADDR, cur_local);
        send_frame(47);
    endtask

    task automatic test_filtering();
        build_ipv4(5, PROTO_ICMP, PEER_ADDR, cur_local);
        frame_buf[12] = 8'h86;
        frame_buf[13] = 8'hDD;
        send_frame(14);
        build_ipv4(5, PROTO_ICMP, PEER_ADDR, cur_local);
        frame_buf[14] = {4'd6, 4'd5};
        send_frame(35);
        build_ipv4(5, PROTO_ICMP, PEER_ADDR, ~cur_local);
        send_frame(35);
        icmp_message(cur_pattern | 32'h0000_00FF, ICMP_ECHO_REQUEST);
    endtask

    task automatic test_icmp_udp();
        icmp_message(PEER_ADDR, ICMP_ECHO_REPLY);
        icmp_message(PEER_ADDR, 8'd3);
        udp_datagram(16'hFFFF);
        udp_datagram(16'd0);
    endtask

    task automatic test_tcp();
        for (int i = 0; i < 10; i++)
            tcp_segment(16'($urandom_range(1, 65535)), service_ports[i], 8'(TCP_FLAG_SYN));
        tcp_segment(16'd1024, 16'd6000, 8'(TCP_FLAG_SYN));
        tcp_segment(16'd0, 16'hFFFF, 8'(TCP_FLAG_SYN));
        tcp_segment(16'hFFFF, PORT_WWW, 8'(TCP_FLAG_FIN));
        tcp_segment(16'd4000, PORT_SSH, TCP_FLAG_ACK | 8'(TCP_FLAG_SYN));
        // the two top flag bits are not examined
        tcp_segment(16'd4001, PORT_SMTP, 8'hC0 | 8'(TCP_FLAG_SYN));
    endtask

    task automatic test_other_protocols();
        build_ipv4(5, PROTO_IGMP, PEER_ADDR, cur_local);
        send_frame(34);
        build_ipv4(5, 8'hFF, PEER_ADDR, cur_local);
        send_frame(40);
    endtask

    task automatic test_header_length();
        // IHL 0: transport starts at the version byte
        build_ipv4(0, PROTO_UDP, PEER_ADDR, cur_local);
        set_ports(0, 16'h4011, 16'hFFFF);
        send_frame(40);
        // IHL 4: ports overlay the destination address
        build_ipv4(4, PROTO_UDP, PEER_ADDR, cur_local);
        send_frame(40);
        build_ipv4(15, PROTO_TCP, PEER_ADDR, cur_local);
        set_ports(15, 16'd2000, PORT_AUTH);
        poke(74 + 13, 8'(TCP_FLAG_SYN));
        send_frame(88);
    endtask

    task automatic test_long_frame();
        build_ipv4(5, PROTO_TCP, PEER_ADDR, cur_local);
        set_ports(5, 16'd3000, PORT_FINGER);
        poke(47, 8'(TCP_FLAG_FIN));
        send_frame(150);
    endtask

    function automatic logic [31:0] pick_src();
        if ($urandom_range(0, 99) < 12)
            return $urandom | cur_pattern;
        return $urandom;
    endfunction

    task automatic random_frame();
        int unsigned ihl;
        int unsigned t0;
        int unsigned tail;
        int unsigned len;
        int unsigned r;
        logic [7:0]  proto;
        logic [7:0]  vb;
        logic [15:0] dport;
        ihl = ($urandom_range(0, 99) < 85) ? 5 : $urandom_range(0, 15);
        t0 = 14 + 4 * ihl;
        r = $urandom_range(0, 99);
        proto = (r < 25) ? PROTO_ICMP : (r < 45) ? PROTO_UDP : (r < 80) ? PROTO_TCP :
                (r < 85) ? PROTO_IGMP : 8'($urandom);
        build_ipv4(ihl, proto, pick_src(),
                   ($urandom_range(0, 99) < 85) ? cur_local : $urandom);
        tail = t0 + 8;
        r = $urandom_range(0, 99);
        case (proto)
            PROTO_ICMP:
                poke(t0, (r < 40) ? ICMP_ECHO_REQUEST : (r < 80) ? ICMP_ECHO_REPLY :
                         8'($urandom));
            PROTO_UDP:
            begin
                dport = (r < 40) ? cur_floor + 16'($urandom_range(0, 3)) :
                        (r < 60) ? cur_floor - 16'd1 : 16'($urandom);
                set_ports(ihl, 16'($urandom), dport);
            end
            PROTO_TCP:
            begin
                dport = (r < 50) ? service_ports[$urandom_range(0, 9)] : 16'($urandom);
                set_ports(ihl, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom), dport);
                r = $urandom_range(0, 99);
                poke(t0 + 13, (r < 35) ? {2'($urandom), TCP_FLAG_SYN} :
                              (r < 60) ? {2'($urandom), TCP_FLAG_FIN} : 8'($urandom));
                tail = t0 + 20;
            end
            default: ;
        endcase
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            frame_buf[12] = 8'($urandom_range(0, 255));
            frame_buf[13] = 8'($urandom_range(0, 255));
        end
        else if (r < 9)
        begin
            vb = frame_buf[14];
            vb[7:4] = 4'($urandom_range(0, 15));
            frame_buf[14] = vb;
        end
        r = $urandom_range(0, 99);
        if (r < 78)
            len = tail + $urandom_range(0, 4);
        else if (r < 90)
            len = $urandom_range(1, tail - 1);
        else if (r < 94)
            len = $urandom_range(120, 150);
        else
            len = $urandom_range(1, 40);
        send_frame(len);
    endtask

    task automatic test_random_traffic();
        int unsigned phase_start;
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            case (k % 5)
                0: apply_setting($urandom, NET_PATTERN_RST, TRACE_PORT_MIN_RST);
                1: apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
                2: apply_setting(32'd0, 32'd0, 16'hFFFF);
                3: apply_setting($urandom, $urandom & $urandom & $urandom,
                                 16'($urandom));
                default: apply_setting($urandom, $urandom, 16'($urandom_range(30000, 40000)));
            endcase
            steady = (k % 3 == 2);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_frame();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        apply_setting(HOST_ADDR, NET_PATTERN_RST, TRACE_PORT_MIN_RST);
        test_truncation();
        test_filtering();
        test_icmp_udp();
        test_tcp();
        test_other_protocols();
        test_header_length();
        test_long_frame();
        test_random_traffic();

        quiesce();
        $display("Ran %0d frames (%0d bytes), checked %0d of %0d expected events",
                 frames_sent, bytes_sent, events_checked, events_expected);
        $display("Register writes: %0d, including all-zero and all-one settings",
                 reg_writes);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
